### design/write_back_data_cache_assert.svh
// Assertion macros used by the checker of the write-back data cache.
// No dependencies; included by the checker file.
`ifndef WRITE_BACK_DATA_CACHE_ASSERT_SVH
`define WRITE_BACK_DATA_CACHE_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define WBDC_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define WBDC_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/wbdc_pkg.sv
// Package of the write-back data cache: default sizes, port widths and
// request type codes. No dependencies.
package wbdc_pkg;

	localparam int MEM_WORDS_DEF   = 32;
	localparam int CACHE_LINES_DEF = 8;
	localparam int WORD_BITS_DEF   = 16;

	localparam int ADDR_BITS = 5;
	localparam int DATA_BITS = 16;
	localparam int TYPE_BITS = 2;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 24;

	localparam logic [TYPE_BITS-1:0] REQ_READ  = 2'd0;
	localparam logic [TYPE_BITS-1:0] REQ_WRITE = 2'd1;
	localparam logic [TYPE_BITS-1:0] REQ_LOAD  = 2'd2;
	localparam logic [TYPE_BITS-1:0] REQ_CLEAR = 2'd3;

endpackage

### design/wbdc_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// No dependencies; used for the cache lines and the backing memory.
module wbdc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                     wdata,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

### design/wbdc_addr_map.sv
// Splits a request address into backing memory address, line index and tag.
// Depends on wbdc_pkg; the tables are built at elaboration.
module wbdc_addr_map #(
	parameter int MEM_WORDS   = 32,
	parameter int CACHE_LINES = 8,
	parameter int MA_W        = 5,
	parameter int IDX_W       = 3,
	parameter int TAG_W       = 2
) (
	input  logic [wbdc_pkg::ADDR_BITS-1:0] address,
	output logic [MA_W-1:0]                maddr,
	output logic [IDX_W-1:0]               idx,
	output logic [TAG_W-1:0]               tag
);
	import wbdc_pkg::*;

	localparam int ADDR_SPAN = 1 << ADDR_BITS;

	logic [MA_W-1:0]  maddr_tab [ADDR_SPAN];
	logic [IDX_W-1:0] idx_tab   [ADDR_SPAN];
	logic [TAG_W-1:0] tag_tab   [ADDR_SPAN];

	for (genvar a = 0; a < ADDR_SPAN; a++) begin : g_tab
		localparam int AM = a % MEM_WORDS;
		localparam int IX = AM % CACHE_LINES;
		localparam int TG = AM / CACHE_LINES;
		assign maddr_tab[a] = MA_W'(AM);
		assign idx_tab[a]   = IDX_W'(IX);
		assign tag_tab[a]   = TAG_W'(TG);
	end

	assign maddr = maddr_tab[address];
	assign idx   = idx_tab[address];
	assign tag   = tag_tab[address];

endmodule

### design/write_back_data_cache.sv
// Direct-mapped write-back data cache with its own backing memory.
// Each transaction reads both single-port RAMs, then does the update and registers
// the result; a clear then clears every cache line after its result.
// The result register frees the input side while a result waits to be taken.
// After reset a clearing pass runs over both RAMs before the first transaction is accepted.
module write_back_data_cache #(
	parameter int MEM_WORDS   = wbdc_pkg::MEM_WORDS_DEF,
	parameter int CACHE_LINES = wbdc_pkg::CACHE_LINES_DEF,
	parameter int WORD_BITS   = wbdc_pkg::WORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// address [4:0], write_data [20:5], zero [23:21]
	input  logic [wbdc_pkg::S_TDATA_W-1:0] s_tdata,
	// req_type [1:0]
	input  logic [wbdc_pkg::TYPE_BITS-1:0] s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// read_data [15:0], hit [16], wrote_back [17], writeback_address [22:18], filled [23]
	output logic [wbdc_pkg::M_TDATA_W-1:0] m_tdata
);
	import wbdc_pkg::*;

	localparam int ADDR_SPAN = 1 << ADDR_BITS;
	localparam int MEM_DEPTH = MEM_WORDS < ADDR_SPAN ? MEM_WORDS : ADDR_SPAN;
	localparam int MA_W      = $clog2(MEM_DEPTH);
	localparam int IDX_W     = CACHE_LINES > 1 ? $clog2(CACHE_LINES) : 1;
	localparam int TAG_MAX   = (MEM_DEPTH - 1) / CACHE_LINES;
	localparam int TAG_W     = TAG_MAX > 0 ? $clog2(TAG_MAX + 1) : 1;
	localparam int SWEEP     = CACHE_LINES > MEM_DEPTH ? CACHE_LINES : MEM_DEPTH;
	localparam int CNT_W     = $clog2(SWEEP);
	localparam int LINE_W    = 2 + TAG_W + WORD_BITS;

	localparam logic [1:0] ST_INIT  = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_LOOK  = 2'd2;
	localparam logic [1:0] ST_CLEAR = 2'd3;

	logic [1:0]           state_q;
	logic [CNT_W-1:0]     cnt_q;

	logic [TYPE_BITS-1:0] type_q;
	logic [MA_W-1:0]      maddr_q;
	logic [IDX_W-1:0]     idx_q;
	logic [TAG_W-1:0]     tag_q;
	logic [WORD_BITS-1:0] wdata_q;

	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	logic [ADDR_BITS-1:0] in_address;
	logic [DATA_BITS-1:0] in_wdata;
	logic [MA_W-1:0]      in_maddr;
	logic [IDX_W-1:0]     in_idx;
	logic [TAG_W-1:0]     in_tag;

	logic                 c_en, c_we;
	logic [IDX_W-1:0]     c_addr;
	logic [LINE_W-1:0]    c_wdata, c_rdata;
	logic                 m_en, m_we;
	logic [MA_W-1:0]      m_addr;
	logic [WORD_BITS-1:0] m_wdata, m_rdata;

	logic                 line_valid, line_dirty;
	logic [TAG_W-1:0]     line_tag;
	logic [WORD_BITS-1:0] line_word;

	logic                 accept, advance, sweep_last;
	logic                 is_read, is_write, is_load, is_clear;
	logic                 hit, do_wb, do_fill;
	logic [ADDR_BITS-1:0] wb_address;
	logic [MA_W-1:0]      wb_maddr;
	logic [WORD_BITS-1:0] result_word;
	logic [M_TDATA_W-1:0] result;

	assign in_address = s_tdata[ADDR_BITS-1:0];
	assign in_wdata   = s_tdata[ADDR_BITS+DATA_BITS-1:ADDR_BITS];

	wbdc_addr_map #(
		.MEM_WORDS  (MEM_WORDS),
		.CACHE_LINES(CACHE_LINES),
		.MA_W       (MA_W),
		.IDX_W      (IDX_W),
		.TAG_W      (TAG_W)
	) u_addr_map (
		.address(in_address),
		.maddr  (in_maddr),
		.idx    (in_idx),
		.tag    (in_tag)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign advance  = (state_q == ST_LOOK) && (!out_valid_q || m_tready);

	assign {line_valid, line_dirty, line_tag, line_word} = c_rdata;

	assign is_read  = (type_q == REQ_READ);
	assign is_write = (type_q == REQ_WRITE);
	assign is_load  = (type_q == REQ_LOAD);
	assign is_clear = (type_q == REQ_CLEAR);

	assign hit     = is_read && line_valid && (line_tag == tag_q);
	assign do_fill = is_read && !hit;
	assign do_wb   = (do_fill && line_valid && line_dirty) || (is_write && line_dirty);

	assign wb_address = ADDR_BITS'(int'(line_tag) * CACHE_LINES + int'(idx_q));
	assign wb_maddr   = MA_W'(int'(line_tag) * CACHE_LINES + int'(idx_q));

	assign result_word = hit ? line_word : m_rdata;
	assign result = {do_fill, do_wb ? wb_address : ADDR_BITS'(0), do_wb, hit,
		is_read ? DATA_BITS'(result_word) : DATA_BITS'(0)};

	assign sweep_last = (state_q == ST_INIT) ? (int'(cnt_q) == SWEEP - 1)
		: (int'(cnt_q) == CACHE_LINES - 1);

	always_comb begin
		c_en    = 1'b0;
		c_we    = 1'b0;
		c_addr  = in_idx;
		c_wdata = {1'b1, is_write, tag_q, is_write ? wdata_q : m_rdata};
		m_en    = 1'b0;
		m_we    = 1'b0;
		m_addr  = in_maddr;
		m_wdata = do_wb ? line_word : wdata_q;
		case (state_q)
			ST_INIT: begin
				c_en    = int'(cnt_q) < CACHE_LINES;
				c_we    = 1'b1;
				c_addr  = cnt_q[IDX_W-1:0];
				c_wdata = '0;
				m_en    = int'(cnt_q) < MEM_DEPTH;
				m_we    = 1'b1;
				m_addr  = cnt_q[MA_W-1:0];
				m_wdata = '0;
			end
			ST_IDLE: begin
				c_en = accept;
				m_en = accept;
			end
			ST_LOOK: begin
				c_en   = advance && (do_fill || is_write);
				c_we   = 1'b1;
				c_addr = idx_q;
				m_en   = advance && (do_wb || is_load);
				m_we   = 1'b1;
				m_addr = do_wb ? wb_maddr : maddr_q;
			end
			ST_CLEAR: begin
				c_en    = 1'b1;
				c_we    = 1'b1;
				c_addr  = cnt_q[IDX_W-1:0];
				c_wdata = '0;
			end
			default: begin
				c_en = 1'b0;
				m_en = 1'b0;
			end
		endcase
	end

	wbdc_ram #(
		.WIDTH(LINE_W),
		.DEPTH(CACHE_LINES)
	) u_line_ram (
		.clk  (clk),
		.en   (c_en),
		.we   (c_we),
		.addr (c_addr),
		.wdata(c_wdata),
		.rdata(c_rdata)
	);

	wbdc_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MEM_DEPTH)
	) u_mem_ram (
		.clk  (clk),
		.en   (m_en),
		.we   (m_we),
		.addr (m_addr),
		.wdata(m_wdata),
		.rdata(m_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_INIT, ST_CLEAR: begin
					if (sweep_last) begin
						state_q <= ST_IDLE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (advance) begin
						state_q <= is_clear ? ST_CLEAR : ST_IDLE;
						cnt_q   <= '0;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_q  <= s_tuser;
			maddr_q <= in_maddr;
			idx_q   <= in_idx;
			tag_q   <= in_tag;
			wdata_q <= WORD_BITS'(in_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

### design/wbdc_checker.sv
// Port-level checker of the write-back data cache, bound to the top level.
// Depends on wbdc_pkg and on the assertion macros in write_back_data_cache_assert.svh.
`include "write_back_data_cache_assert.svh"

module wbdc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [wbdc_pkg::M_TDATA_W-1:0] m_tdata
);
	import wbdc_pkg::*;

	logic       r_hit, r_wb, r_fill;
	logic [4:0] r_wb_addr;

	assign r_hit     = m_tdata[16];
	assign r_wb      = m_tdata[17];
	assign r_wb_addr = m_tdata[22:18];
	assign r_fill    = m_tdata[23];

	`WBDC_ASSERT(a_result_held, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "Result changed while stalled.")
	`WBDC_ASSERT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "Transaction accepted while another is in work.")
	`WBDC_ASSERT(a_hit_exclusive, clk, arst_n, m_tvalid && r_hit |-> !r_fill && !r_wb, "Hit reported with fill or write-back.")
	`WBDC_ASSERT(a_wb_address_zero, clk, arst_n, m_tvalid && !r_wb |-> r_wb_addr == 5'd0, "Write-back address without write-back.")
	`WBDC_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !m_tvalid && !s_tready, "Handshake active after reset.")

endmodule

bind write_back_data_cache wbdc_checker u_wbdc_checker (.*);
